FILE: rtl/frame_diff_bbox_counter_top_defines.svh
// Assertion macros for the frame difference bounding box RTL.
`ifndef FRAME_DIFF_BBOX_COUNTER_TOP_DEFINES_SVH
`define FRAME_DIFF_BBOX_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FDBB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FDBB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fdbb_pkg.sv
// Package with the widths, register indexes and shared types of the frame difference block.
`default_nettype none

package fdbb_pkg;

    // Field and state widths.
    localparam int PIXEL_BITS = 16;
    localparam int DIM_W      = 13;
    localparam int POS_W      = 12;
    localparam int CNT_W      = 25;
    localparam int CFG_IDX_W  = 3;

    // Largest frame dimension; larger register values act as this one.
    localparam int MAX_DIM = 4096;
    localparam logic [DIM_W-1:0] DIM_MAX_VAL = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] DIM_MIN_VAL = DIM_W'(1);

    // Reset values of the configuration registers.
    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH   = 13'd1920;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT  = 13'd1080;
    localparam logic [DIM_W-1:0] RST_WINDOW_LEFT   = 13'd0;
    localparam logic [DIM_W-1:0] RST_WINDOW_TOP    = 13'd0;
    localparam logic [DIM_W-1:0] RST_WINDOW_RIGHT  = 13'd1920;
    localparam logic [DIM_W-1:0] RST_WINDOW_BOTTOM = 13'd1080;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_WINDOW_LEFT   = 3'd2,
        REG_WINDOW_TOP    = 3'd3,
        REG_WINDOW_RIGHT  = 3'd4,
        REG_WINDOW_BOTTOM = 3'd5
    } cfg_index_t;

    // Effective frame size and clipped window, as seen by the accumulator.
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] left;
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] right;
        logic [DIM_W-1:0] bottom;
    } frame_geom_t;

    // One registered pixel beat with its position.
    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_old;
        logic [PIXEL_BITS-1:0] pixel_new;
        logic [POS_W-1:0]      col;
        logic [POS_W-1:0]      row;
        logic                  frame_end;
    } pix_beat_t;

endpackage

`default_nettype wire

FILE: rtl/fdbb_if.sv
// Valid/ready channel interfaces for pixel pair beats and frame result beats.
`default_nettype none

interface fdbb_pix_if
    import fdbb_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_old;
    logic [PIXEL_BITS-1:0] pixel_new;

    modport source (output valid, output pixel_old, output pixel_new, input ready);
    modport sink   (input valid, input pixel_old, input pixel_new, output ready);
endinterface

interface fdbb_res_if
    import fdbb_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] changed_count;
    logic             any_changed;
    logic [DIM_W-1:0] box_min_x;
    logic [DIM_W-1:0] box_min_y;
    logic [POS_W-1:0] box_max_x;
    logic [POS_W-1:0] box_max_y;

    modport source (
        output valid, output changed_count, output any_changed,
        output box_min_x, output box_min_y, output box_max_x, output box_max_y,
        input ready
    );
    modport sink (
        input valid, input changed_count, input any_changed,
        input box_min_x, input box_min_y, input box_max_x, input box_max_y,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/frame_diff_bbox_counter_top.sv
// Top level of the frame difference counter with bounding box.
`default_nettype none

// Takes one pair of co-located pixels from two frames per clock in raster order and
// tracks column and row itself from the configured frame size (0 acts as 1, sizes
// above 4096 act as 4096). Pairs that differ inside the window, clipped to the frame,
// are counted and their least and greatest column and row kept. One result beat
// is presented per frame once its last pixel has passed the input register and
// then the result register; a frame with no change reports width, height,
// 0, 0. Throughput is one pixel beat per clock: the block holds off input only when
// a frame-end beat finds the previous frame's result still waiting at the output
// register. There is no clearing pass after reset. Write the configuration
// registers only while no beat is in flight.
module frame_diff_bbox_counter_top
    import fdbb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [DIM_W-1:0]     cfg_data,
    fdbb_pix_if.sink                  pix_in,
    fdbb_res_if.source                res_out
);

`include "frame_diff_bbox_counter_top_defines.svh"

    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic [DIM_W-1:0] window_left_reg;
    logic [DIM_W-1:0] window_top_reg;
    logic [DIM_W-1:0] window_right_reg;
    logic [DIM_W-1:0] window_bottom_reg;

    logic [POS_W-1:0] col_reg;
    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] col_next;
    logic [POS_W-1:0] row_next;

    logic             beat_valid_reg;
    pix_beat_t        beat_reg;
    logic             beat_take;

    frame_geom_t      geom;
    logic [DIM_W-1:0] col_plus;
    logic [DIM_W-1:0] row_plus;
    logic             row_end;
    logic             frame_end;
    logic             in_fire;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= RST_FRAME_WIDTH;
            frame_height_reg  <= RST_FRAME_HEIGHT;
            window_left_reg   <= RST_WINDOW_LEFT;
            window_top_reg    <= RST_WINDOW_TOP;
            window_right_reg  <= RST_WINDOW_RIGHT;
            window_bottom_reg <= RST_WINDOW_BOTTOM;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data;
                REG_FRAME_HEIGHT:  frame_height_reg  <= cfg_data;
                REG_WINDOW_LEFT:   window_left_reg   <= cfg_data;
                REG_WINDOW_TOP:    window_top_reg    <= cfg_data;
                REG_WINDOW_RIGHT:  window_right_reg  <= cfg_data;
                REG_WINDOW_BOTTOM: window_bottom_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Effective frame size and window clipped to it.
    always_comb
    begin
        geom.width  = (frame_width_reg == '0) ? DIM_MIN_VAL :
                      (frame_width_reg > DIM_MAX_VAL) ? DIM_MAX_VAL : frame_width_reg;
        geom.height = (frame_height_reg == '0) ? DIM_MIN_VAL :
                      (frame_height_reg > DIM_MAX_VAL) ? DIM_MAX_VAL : frame_height_reg;
        geom.left   = window_left_reg;
        geom.top    = window_top_reg;
        geom.right  = (window_right_reg < geom.width) ? window_right_reg : geom.width;
        geom.bottom = (window_bottom_reg < geom.height) ? window_bottom_reg : geom.height;
    end

    // Raster position: a column at or past the last one wraps to the next row.
    assign col_plus  = {1'b0, col_reg} + DIM_W'(1);
    assign row_plus  = {1'b0, row_reg} + DIM_W'(1);
    assign row_end   = (col_plus >= geom.width);
    assign frame_end = row_end && (row_plus >= geom.height);
    assign col_next  = row_end ? '0 : col_plus[POS_W-1:0];
    assign row_next  = frame_end ? '0 : (row_end ? row_plus[POS_W-1:0] : row_reg);

    assign pix_in.ready = !beat_valid_reg || beat_take;
    assign in_fire      = pix_in.valid && pix_in.ready;

    // Position counters advance on every accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Input stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_valid_reg <= 1'b0;
        end
        else if (pix_in.ready)
        begin
            beat_valid_reg <= pix_in.valid;
        end
    end

    // Input stage payload with the position it was taken at.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            beat_reg.pixel_old <= pix_in.pixel_old;
            beat_reg.pixel_new <= pix_in.pixel_new;
            beat_reg.col       <= col_reg;
            beat_reg.row       <= row_reg;
            beat_reg.frame_end <= frame_end;
        end
    end

    fdbb_accum u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .geom       (geom),
        .beat_valid (beat_valid_reg),
        .beat       (beat_reg),
        .beat_take  (beat_take),
        .res        (res_out)
    );

    // A frame-end beat that moves on always leaves a result behind.
    `FDBB_ASSERT_NEXT(a_frame_end_gives_result,
        beat_valid_reg && beat_take && beat_reg.frame_end, res_out.valid,
        "frame end beat produced no result")

    // A beat that is held stays in the input stage.
    `FDBB_ASSERT_NEXT(a_stalled_beat_kept,
        beat_valid_reg && !beat_take, beat_valid_reg,
        "stalled beat dropped from input stage")

    // The change flag agrees with the count.
    `FDBB_ASSERT_NOW(a_flag_matches_count,
        res_out.valid, res_out.any_changed == (res_out.changed_count != '0),
        "change flag disagrees with count")

    // A frame without change reports the whole frame as its box.
    `FDBB_ASSERT_NOW(a_empty_box,
        res_out.valid && !res_out.any_changed,
        (res_out.box_min_x == geom.width) && (res_out.box_min_y == geom.height)
            && (res_out.box_max_x == '0) && (res_out.box_max_y == '0),
        "empty frame box is not the full frame")

endmodule

`default_nettype wire

FILE: rtl/fdbb_accum.sv
// Change counter, bounding box accumulator and frame result register.
`default_nettype none

module fdbb_accum
    import fdbb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire frame_geom_t geom,
    input  wire logic        beat_valid,
    input  wire pix_beat_t   beat,
    output logic             beat_take,
    fdbb_res_if.source       res
);

    logic             out_valid_reg;
    logic [CNT_W-1:0] out_count_reg;
    logic             out_any_reg;
    logic [DIM_W-1:0] out_min_x_reg;
    logic [DIM_W-1:0] out_min_y_reg;
    logic [POS_W-1:0] out_max_x_reg;
    logic [POS_W-1:0] out_max_y_reg;

    logic [CNT_W-1:0] count_reg;
    logic [DIM_W-1:0] min_x_reg;
    logic [DIM_W-1:0] min_y_reg;
    logic [POS_W-1:0] max_x_reg;
    logic [POS_W-1:0] max_y_reg;

    logic [CNT_W-1:0] count_next;
    logic [DIM_W-1:0] min_x_next;
    logic [DIM_W-1:0] min_y_next;
    logic [POS_W-1:0] max_x_next;
    logic [POS_W-1:0] max_y_next;

    logic [DIM_W-1:0] col_ext;
    logic [DIM_W-1:0] row_ext;
    logic             in_window;
    logic             hit;
    logic             first_hit;
    logic             emit;

    // A beat that ends a frame waits until the result register is free.
    assign beat_take = beat_valid && (!beat.frame_end || !out_valid_reg || res.ready);
    assign emit      = beat_take && beat.frame_end;

    // Window test and pixel compare.
    assign col_ext   = {1'b0, beat.col};
    assign row_ext   = {1'b0, beat.row};
    assign in_window = (col_ext >= geom.left) && (col_ext < geom.right)
                    && (row_ext >= geom.top) && (row_ext < geom.bottom);
    assign hit       = in_window && (beat.pixel_old != beat.pixel_new);
    assign first_hit = (count_reg == '0);

    // Accumulator update for the current beat; the first change loads the box.
    always_comb
    begin
        count_next = count_reg;
        min_x_next = min_x_reg;
        min_y_next = min_y_reg;
        max_x_next = max_x_reg;
        max_y_next = max_y_reg;
        if (hit)
        begin
            count_next = count_reg + CNT_W'(1);
            if (first_hit)
            begin
                min_x_next = col_ext;
                min_y_next = row_ext;
                max_x_next = beat.col;
                max_y_next = beat.row;
            end
            else
            begin
                if (col_ext < min_x_reg)
                begin
                    min_x_next = col_ext;
                end
                if (row_ext < min_y_reg)
                begin
                    min_y_next = row_ext;
                end
                if (beat.col > max_x_reg)
                begin
                    max_x_next = beat.col;
                end
                if (beat.row > max_y_reg)
                begin
                    max_y_next = beat.row;
                end
            end
        end
    end

    // Count register; cleared after each frame result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (beat_take)
        begin
            count_reg <= emit ? '0 : count_next;
        end
    end

    // Box registers only matter while the count is nonzero.
    always_ff @(posedge clk)
    begin
        if (beat_take)
        begin
            min_x_reg <= min_x_next;
            min_y_reg <= min_y_next;
            max_x_reg <= max_x_next;
            max_y_reg <= max_y_next;
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload; a frame with no change reports the full frame as the box.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_count_reg <= count_next;
            if (count_next == '0)
            begin
                out_any_reg   <= 1'b0;
                out_min_x_reg <= geom.width;
                out_min_y_reg <= geom.height;
                out_max_x_reg <= '0;
                out_max_y_reg <= '0;
            end
            else
            begin
                out_any_reg   <= 1'b1;
                out_min_x_reg <= min_x_next;
                out_min_y_reg <= min_y_next;
                out_max_x_reg <= max_x_next;
                out_max_y_reg <= max_y_next;
            end
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.changed_count = out_count_reg;
    assign res.any_changed   = out_any_reg;
    assign res.box_min_x     = out_min_x_reg;
    assign res.box_min_y     = out_min_y_reg;
    assign res.box_max_x     = out_max_x_reg;
    assign res.box_max_y     = out_max_y_reg;

endmodule

`default_nettype wire
